FILE: sv/bitmap_slab_page_allocator_core_defines.svh
// Assertion macros for the checker of the slab page allocator.
`ifndef BITMAP_SLAB_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_SLAB_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define BSPA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle property violated");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define BSPA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle property violated");

`endif

FILE: sv/bspa_pkg.sv
// Shared types, codes and size-class helpers of the slab page allocator.
package bspa_pkg;

   // Size-class table geometry.
   localparam int CLASS_COUNT = 29;
   localparam int LAST_CLASS  = 28;

   // Request operations.
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_DOUBLE = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   // Control sequencer states.
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_ADDR = 2'd1,
      S_DATA = 2'd2,
      S_MUL  = 2'd3
   } state_type;

   // Reciprocals ceil(2^16 / m) for the block size mantissa m = 4..7.
   localparam logic [14:0] RECIP [4] = '{15'd16384, 15'd13108, 15'd10923, 15'd9363};

   // Every block size is m << s with m in 4..7: m comes from the low class
   // bits and s from the high ones.
   function automatic logic [12:0] class_bytes(logic [4:0] c);
      logic [12:0] m;
      m = 13'(3'd4 + 3'(c[1:0]));
      return m << (4'd3 + 4'(c[4:2]));
   endfunction

   // Register values past the table act as the largest class.
   function automatic logic [4:0] clamp_class(logic [4:0] v);
      return (v > 5'(LAST_CLASS)) ? 5'(LAST_CLASS) : v;
   endfunction

   // Occupancy word after page initialization: bits at or past the block
   // count are marked used.
   function automatic logic [63:0] init_word(logic [11:0] base, logic [11:0] n);
      logic [11:0] d;
      d = n - base;
      if (n <= base) begin
         return '1;
      end else if (d >= 12'd64) begin
         return '0;
      end else begin
         return {64{1'b1}} << d[5:0];
      end
   endfunction

endpackage

FILE: sv/bspa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bspa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/bspa_div.sv
// Byte offset to block index conversion by a reciprocal multiply.
module bspa_div (
   input  logic        clock,
   input  logic        load,
   input  logic [4:0]  size_class,
   input  logic [15:0] byte_offset,
   output logic [10:0] block_index
);
   import bspa_pkg::*;

   logic [3:0]  shift;
   logic [12:0] scaled;
   logic [27:0] product;
   logic [10:0] quot_ff;

   // Strip the power-of-two part of the block size, then divide by the
   // mantissa through its reciprocal. The reciprocal error stays below one
   // step for every 13-bit dividend, so no correction is needed.
   always_comb begin
      shift   = 4'd3 + 4'(size_class[4:2]);
      scaled  = 13'(byte_offset >> shift);
      product = 28'(scaled) * 28'(RECIP[size_class[1:0]]);
   end

   // Quotient register, loaded when a request is taken.
   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= product[26:16];
      end
   end

   assign block_index = quot_ff;

endmodule

FILE: sv/bitmap_slab_page_allocator_core.sv
// Top level of the bitmap slab page allocator: sequencer, summary flags and map RAM.
//
// Usage:
//  - Request channel: a request is taken at a rising edge where start is high
//    and busy is low. req_cmd selects allocate or free; req_block_offset is the
//    byte offset freed.
//  - Response channel: rsp_strobe is high for one cycle with rsp_status,
//    rsp_alloc_offset, rsp_used_blocks and rsp_total_blocks. The receiver
//    cannot stall; each request yields exactly one response.
//  - Sequence: an allocate runs through S_ADDR, S_DATA and S_MUL (word select
//    from the full-word summary flags, map RAM read, first-free search and
//    write-back, offset multiply), then responds. A free runs through S_ADDR
//    and S_DATA (reciprocal divide, map RAM read, bit check and write-back). A
//    full page or out-of-range offset responds straight from S_ADDR.
//  - Throughput: one request at a time; busy is low in the response cycle, so
//    the next request may be taken then. The map RAM read-modify-write sets it.
//  - Configuration: csr_we with csr_wdata writes the size class and resets the
//    page at once; write it only while idle.
//  - Reset: size class 0, page empty, no response pending. Per-word valid flags
//    make unwritten map words read as their initial value, so no clearing pass.
module bitmap_slab_page_allocator_core #(
   parameter int PAGE_BYTES = 65536,
   parameter int MAP_WORDS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [15:0]          req_block_offset,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_alloc_offset,
   output logic [11:0]          rsp_used_blocks,
   output logic [11:0]          rsp_total_blocks,
   input  logic                 csr_we,
   input  logic [4:0]           csr_wdata
);
   import bspa_pkg::*;

   localparam int WW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int MAX_BLOCKS = MAP_WORDS * 64;

   // Block count per class, worked out at elaboration.
   logic [11:0] tot_tbl [CLASS_COUNT];
   for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_total
      localparam int RAW     = PAGE_BYTES / int'(class_bytes(5'(c)));
      localparam int CLAMPED = (RAW > MAX_BLOCKS) ? MAX_BLOCKS : RAW;
      assign tot_tbl[c] = 12'(CLAMPED);
   end

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [4:0]         class_ff;
   logic [11:0]        total_ff;
   logic [11:0]        used_ff, used_in;
   logic [MAP_WORDS-1:0] valid_ff, full_ff, full_init;
   logic [WW-1:0]      word_ff, word_in;
   logic [10:0]        index_ff, index_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_offset_ff, rsp_offset_in;
   logic [11:0]        rsp_used_ff;

   logic [4:0]         cfg_class;
   logic [11:0]        cfg_total;
   logic               accept;
   logic [10:0]        quot;
   logic               any_free;
   logic [WW-1:0]      free_word;
   logic [11:0]        word_base;
   logic [63:0]        cur_word, new_word;
   logic [5:0]         zero_bit;
   logic [12:0]        bsz;
   logic [23:0]        offset_prod;
   logic               ram_we;
   logic [WW-1:0]      ram_raddr;
   logic [63:0]        ram_rdata;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Class and block count loaded by reset or a register write.
   always_comb begin
      cfg_class = reset ? '0 : clamp_class(csr_wdata);
      cfg_total = tot_tbl[cfg_class];
      for (int i = 0; i < MAP_WORDS; i++) begin
         full_init[i] = (12'(i * 64) >= cfg_total);
      end
   end

   // Offset to block index, loaded on each accepted request.
   bspa_div u_div (
      .clock       (clock),
      .load        (accept),
      .size_class  (class_ff),
      .byte_offset (req_block_offset),
      .block_index (quot)
   );

   // Occupancy map storage.
   bspa_ram #(
      .WIDTH (64),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (word_ff),
      .wdata (new_word),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Lowest word that still has a free block, from the summary flags.
   always_comb begin
      free_word = '0;
      for (int i = MAP_WORDS - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            free_word = WW'(i);
         end
      end
      any_free = ~&full_ff;
   end

   // Current map word: RAM data once written, the initial pattern before.
   always_comb begin
      word_base = 12'(word_ff) << 6;
      cur_word  = valid_ff[word_ff] ? ram_rdata : init_word(word_base, total_ff);
      zero_bit  = '0;
      for (int j = 63; j >= 0; j--) begin
         if (!cur_word[j]) begin
            zero_bit = 6'(j);
         end
      end
   end

   // Byte offset of the allocated block.
   always_comb begin
      bsz         = class_bytes(class_ff);
      offset_prod = 24'(index_ff) * 24'(bsz);
   end

   // Sequencer: next state, RAM control and response.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      index_in      = index_ff;
      used_in       = used_ff;
      ram_we        = 1'b0;
      ram_raddr     = word_ff;
      new_word      = cur_word;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_offset_in = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_cmd);
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (any_free) begin
                  ram_raddr = free_word;
                  word_in   = free_word;
                  state_in  = S_DATA;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_FULL;
                  state_in      = S_IDLE;
               end
            end else begin
               if ({1'b0, quot} >= total_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_IDLE;
               end else begin
                  ram_raddr = quot[6 +: WW];
                  word_in   = quot[6 +: WW];
                  state_in  = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (cmd_ff == CMD_ALLOC) begin
               new_word = cur_word | (64'd1 << zero_bit);
               ram_we   = 1'b1;
               used_in  = used_ff + 12'd1;
               index_in = 11'({word_ff, zero_bit});
               state_in = S_MUL;
            end else if (!cur_word[quot[5:0]]) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_DOUBLE;
               state_in      = S_IDLE;
            end else begin
               new_word      = cur_word & ~(64'd1 << quot[5:0]);
               ram_we        = 1'b1;
               used_in       = used_ff - 12'd1;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_MUL: begin
            rsp_strobe_in = 1'b1;
            rsp_offset_in = offset_prod[15:0];
            state_in      = S_IDLE;
         end
      endcase
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Page control state: class, count, summary and valid flags.
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         class_ff <= cfg_class;
         total_ff <= cfg_total;
         used_ff  <= '0;
         valid_ff <= '0;
         full_ff  <= full_init;
      end else begin
         used_ff <= used_in;
         if (ram_we) begin
            valid_ff[word_ff] <= 1'b1;
            full_ff[word_ff]  <= &new_word;
         end
      end
   end

   // Response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      word_ff  <= word_in;
      index_ff <= index_in;
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_used_ff   <= used_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_offset_ff;
   assign rsp_used_blocks  = rsp_used_ff;
   assign rsp_total_blocks = total_ff;

endmodule

FILE: sv/bspa_checker.sv
// Port-level checker for the slab page allocator, bound to the top level.
`include "bitmap_slab_page_allocator_core_defines.svh"

module bspa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_alloc_offset,
   input logic [11:0] rsp_used_blocks,
   input logic [11:0] rsp_total_blocks
);
   import bspa_pkg::*;

   // A taken request keeps the block busy in the next cycle.
   `BSPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // A response is delivered only as the block goes idle.
   `BSPA_ASSERT_SAME(a_rsp_idle, rsp_strobe, !busy)

   // The page never reports more blocks in use than it holds.
   `BSPA_ASSERT_SAME(a_used_bound, rsp_strobe, rsp_used_blocks <= rsp_total_blocks)

   // Only a successful request carries a nonzero offset.
   `BSPA_ASSERT_SAME(a_offset_zero, rsp_strobe && (rsp_status != ST_OK),
                     rsp_alloc_offset == 16'd0)

endmodule

bind bitmap_slab_page_allocator_core bspa_checker u_bspa_checker (.*);
